// ===== hw/rtl/kvt_pkg.sv =====
// Shared types and constants for the keyed reference value table.
// Holds table sizing, operation and status codes, and the cell structs.
// No dependencies.
`default_nettype none

package kvt_pkg;

   // Table sizing
   localparam int TABLE_DEPTH = 16;
   localparam int KEY_BITS    = 31;
   localparam int VALUE_BITS  = 64;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

   // Largest key, and the limit above which a new key is refused on store
   localparam logic [KEY_BITS-1:0] KEY_MAX   = '1;
   localparam logic [KEY_BITS-1:0] KEY_LIMIT = KEY_MAX >> 1;

   // Operation codes
   localparam logic [2:0] OP_LOOKUP       = 3'd0;
   localparam logic [2:0] OP_STORE        = 3'd1;
   localparam logic [2:0] OP_CLEAR_ALL    = 3'd2;
   localparam logic [2:0] OP_ALLOCATE     = 3'd3;
   localparam logic [2:0] OP_LOOKUP_STORE = 3'd4;

   // Result status codes
   localparam logic [2:0] STS_NOOP        = 3'd0;
   localparam logic [2:0] STS_RETURNED    = 3'd1;
   localparam logic [2:0] STS_NOT_SET     = 3'd2;
   localparam logic [2:0] STS_NONEXISTENT = 3'd3;
   localparam logic [2:0] STS_STORED      = 3'd4;
   localparam logic [2:0] STS_ERROR       = 3'd5;

   // Search result handed from cell to cell
   typedef struct packed {
      logic                  hit;
      logic                  set;
      logic [VALUE_BITS-1:0] value;
      logic [IDX_BITS-1:0]   idx;
   } probe_type;

   // Write command broadcast to every cell
   typedef struct packed {
      logic                  wr;
      logic                  wr_key;
      logic                  clear_all;
      logic [IDX_BITS-1:0]   idx;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic                  set;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/kvt_cell.sv =====
// One table entry: key, value and set mark, plus one stage of the search chain.
// Depends on kvt_pkg.
`default_nettype none

module kvt_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [kvt_pkg::IDX_BITS-1:0] cell_idx,
   input  wire logic [kvt_pkg::CNT_BITS-1:0] entry_count,
   input  wire logic [kvt_pkg::KEY_BITS-1:0] search_key,
   input  wire kvt_pkg::cell_cmd_type        cmd,
   input  wire kvt_pkg::probe_type           probe_prev,
   output kvt_pkg::probe_type                probe_next
);

   logic [kvt_pkg::KEY_BITS-1:0]   key_ff;
   logic [kvt_pkg::VALUE_BITS-1:0] value_ff;
   logic                           set_ff;
   kvt_pkg::probe_type             probe_in;
   kvt_pkg::probe_type             probe_ff;
   logic                           valid;
   logic                           sel;

   // Entry is live when its index is below the fill count
   assign valid = kvt_pkg::CNT_BITS'(cell_idx) < entry_count;
   assign sel   = cmd.wr && (cmd.idx == cell_idx);

   // Claim the probe if no earlier cell has matched
   always_comb begin
      probe_in = probe_prev;
      if (!probe_prev.hit && valid && (key_ff == search_key)) begin
         probe_in.hit   = 1'b1;
         probe_in.set   = set_ff;
         probe_in.value = value_ff;
         probe_in.idx   = cell_idx;
      end
   end

   // Advance the probe one cell per cycle
   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
   end

   assign probe_next = probe_ff;

   // Hold key and value until written
   always_ff @(posedge clock) begin
      if (sel) begin
         value_ff <= cmd.value;
         if (cmd.wr_key) begin
            key_ff <= cmd.key;
         end
      end
   end

   // Set mark: drop on reset or clear-all, load on write
   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff <= 1'b0;
      end else if (cmd.clear_all) begin
         set_ff <= 1'b0;
      end else if (sel) begin
         set_ff <= cmd.set;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/keyed_reference_value_table.sv =====
// Top level of the keyed reference value table: request sequencer, cell row
// and result register. Depends on kvt_pkg and kvt_cell.
`default_nettype none

// Each request is taken when start is high and busy is low, and answers with
// exactly one result, shown for one cycle with rsp_strobe high; the receiver
// cannot stall it. A new request may be accepted in the cycle the result is
// shown. The search sets the pace: a match probe walks the row of entry cells
// one cell per cycle, so the first matching key wins, followed by the apply
// state, which applies the update and registers the result. Keys are searched
// from entry 0 upward.
module keyed_reference_value_table (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [2:0]                     req_op,
   input  wire logic [kvt_pkg::KEY_BITS-1:0]   req_ref_key,
   input  wire logic [kvt_pkg::VALUE_BITS-1:0] req_value_in,
   output logic                                rsp_strobe,
   output logic [2:0]                          rsp_status,
   output logic [kvt_pkg::VALUE_BITS-1:0]      rsp_value_out,
   output logic [kvt_pkg::KEY_BITS-1:0]        rsp_key_out
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_APPLY  = 3'b100
   } state_type;

   state_type                      state_ff;
   state_type                      state_in;
   logic [kvt_pkg::IDX_BITS-1:0]   search_cnt_ff;
   logic [2:0]                     op_ff;
   logic [kvt_pkg::KEY_BITS-1:0]   key_ff;
   logic [kvt_pkg::VALUE_BITS-1:0] value_ff;
   logic [kvt_pkg::CNT_BITS-1:0]   count_ff;
   logic [kvt_pkg::CNT_BITS-1:0]   count_in;
   logic [kvt_pkg::KEY_BITS-1:0]   fresh_ff;
   logic [kvt_pkg::KEY_BITS-1:0]   fresh_in;
   logic                           strobe_ff;
   logic [2:0]                     status_ff;
   logic [2:0]                     status_in;
   logic [kvt_pkg::VALUE_BITS-1:0] vout_ff;
   logic [kvt_pkg::VALUE_BITS-1:0] vout_in;
   logic [kvt_pkg::KEY_BITS-1:0]   kout_ff;
   logic [kvt_pkg::KEY_BITS-1:0]   kout_in;
   kvt_pkg::cell_cmd_type          cmd;
   kvt_pkg::probe_type             probe_chain [kvt_pkg::TABLE_DEPTH+1];
   kvt_pkg::probe_type             found;
   logic                           accept;
   logic                           key_zero;
   logic                           full;
   logic                           too_large;
   logic                           store_ok;
   kvt_pkg::cell_cmd_type          store_cmd;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Sequencer: idle, walk the cell row, apply
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (search_cnt_ff == kvt_pkg::IDX_BITS'(kvt_pkg::TABLE_DEPTH - 1)) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         search_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_SEARCH) begin
            search_cnt_ff <= search_cnt_ff + 1'b1;
         end else begin
            search_cnt_ff <= '0;
         end
      end
   end

   // Capture the request on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         key_ff   <= req_ref_key;
         value_ff <= req_value_in;
      end
   end

   // Row of entry cells; the probe enters at cell 0
   assign probe_chain[0] = '0;

   for (genvar i = 0; i < kvt_pkg::TABLE_DEPTH; i++) begin : g_cell
      kvt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (kvt_pkg::IDX_BITS'(i)),
         .entry_count (count_ff),
         .search_key  (key_ff),
         .cmd         (cmd),
         .probe_prev  (probe_chain[i]),
         .probe_next  (probe_chain[i+1])
      );
   end

   assign found = probe_chain[kvt_pkg::TABLE_DEPTH];

   // Conditions shared by the operations
   assign key_zero  = (key_ff == '0);
   assign full      = (count_ff == kvt_pkg::CNT_BITS'(kvt_pkg::TABLE_DEPTH));
   assign too_large = (key_ff > kvt_pkg::KEY_LIMIT);

   // Store rule: overwrite a found key, else append a key within the limit if not full
   always_comb begin
      store_cmd        = '0;
      store_cmd.key    = key_ff;
      store_cmd.value  = value_ff;
      store_cmd.set    = 1'b1;
      store_ok         = 1'b0;
      if (found.hit) begin
         store_cmd.wr  = 1'b1;
         store_cmd.idx = found.idx;
         store_ok      = 1'b1;
      end else if (!too_large && !full) begin
         store_cmd.wr     = 1'b1;
         store_cmd.wr_key = 1'b1;
         store_cmd.idx    = count_ff[kvt_pkg::IDX_BITS-1:0];
         store_ok         = 1'b1;
      end
   end

   // Decode the operation in the apply cycle
   always_comb begin
      cmd       = '0;
      status_in = kvt_pkg::STS_ERROR;
      vout_in   = '0;
      kout_in   = key_ff;
      count_in  = count_ff;
      fresh_in  = fresh_ff;
      if (state_ff == S_APPLY) begin
         unique case (op_ff)
            kvt_pkg::OP_LOOKUP: begin
               if (key_zero) begin
                  status_in = kvt_pkg::STS_NOOP;
               end else if (found.hit && found.set) begin
                  status_in = kvt_pkg::STS_RETURNED;
                  vout_in   = found.value;
               end else if (found.hit) begin
                  status_in = kvt_pkg::STS_NOT_SET;
               end else begin
                  status_in = kvt_pkg::STS_NONEXISTENT;
               end
            end
            kvt_pkg::OP_LOOKUP_STORE: begin
               if (key_zero) begin
                  status_in = kvt_pkg::STS_NOOP;
                  vout_in   = value_ff;
               end else if (found.hit && found.set) begin
                  status_in = kvt_pkg::STS_RETURNED;
                  vout_in   = found.value;
               end else if (store_ok) begin
                  cmd       = store_cmd;
                  status_in = kvt_pkg::STS_STORED;
                  vout_in   = value_ff;
                  if (!found.hit) begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            kvt_pkg::OP_STORE: begin
               if (key_zero) begin
                  status_in = kvt_pkg::STS_NOOP;
               end else if (store_ok) begin
                  cmd       = store_cmd;
                  status_in = kvt_pkg::STS_STORED;
                  if (!found.hit) begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            kvt_pkg::OP_CLEAR_ALL: begin
               cmd.clear_all = 1'b1;
               status_in     = kvt_pkg::STS_STORED;
            end
            kvt_pkg::OP_ALLOCATE: begin
               if (full) begin
                  kout_in = '0;
               end else begin
                  cmd.wr     = 1'b1;
                  cmd.wr_key = 1'b1;
                  cmd.idx    = count_ff[kvt_pkg::IDX_BITS-1:0];
                  cmd.key    = fresh_ff;
                  status_in  = kvt_pkg::STS_STORED;
                  kout_in    = fresh_ff;
                  count_in   = count_ff + 1'b1;
                  fresh_in   = fresh_ff - 1'b1;
               end
            end
            default: begin
               status_in = kvt_pkg::STS_ERROR;
            end
         endcase
      end
   end

   // Table bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fresh_ff <= kvt_pkg::KEY_MAX;
      end else if (state_ff == S_APPLY) begin
         count_ff <= count_in;
         fresh_ff <= fresh_in;
      end
   end

   // Result register and strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (state_ff == S_APPLY);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_APPLY) begin
         status_ff <= status_in;
         vout_ff   <= vout_in;
         kout_ff   <= kout_in;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_key_out   = kout_ff;

`ifndef SYNTHESIS
   // A result transfer lasts one cycle only
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // An accepted request keeps the block busy through the search
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_strobe)
      else $error("request accepted without entering the search");

   // Fill count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= kvt_pkg::CNT_BITS'(kvt_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // A granted allocation consumes exactly the key it returns
   a_alloc_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (op_ff == kvt_pkg::OP_ALLOCATE) &&
      (rsp_status == kvt_pkg::STS_STORED) |->
      (fresh_ff == kvt_pkg::KEY_BITS'(rsp_key_out - 1'b1)))
      else $error("fresh key not advanced after allocation");

   // A result is only shown right after the apply cycle
   a_strobe_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_APPLY)
      else $error("result strobe without apply cycle");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for keyed_reference_value_table: directed and random requests.
// A built-in table predictor checks every result. Depends on kvt_pkg and the table RTL.
module tb_top;
   import kvt_pkg::*;

   localparam logic [2:0] OP_UNDEFINED_LO = 3'd5;
   localparam logic [2:0] OP_UNDEFINED_HI = 3'd7;
   localparam int         HOME_KEYS       = 10;
   localparam int         RANDOM_ITEMS    = 1650;
   localparam int         TAIL_CYCLES     = TABLE_DEPTH + 8;
   localparam int         CYCLE_LIMIT     = 400000;

   typedef struct {
      logic [2:0]            op;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      int unsigned           gap;
      bit                    drain;
   } table_request_type;

   typedef struct {
      logic [2:0]            status;
      logic [VALUE_BITS-1:0] value;
      logic [KEY_BITS-1:0]   key;
   } table_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [2:0]            req_op = OP_LOOKUP;
   logic [KEY_BITS-1:0]   req_ref_key = '0;
   logic [VALUE_BITS-1:0] req_value_in = '0;
   logic                  rsp_strobe;
   logic [2:0]            rsp_status;
   logic [VALUE_BITS-1:0] rsp_value_out;
   logic [KEY_BITS-1:0]   rsp_key_out;

   // Stimulus and scoreboard storage
   table_request_type     request_queue[$];
   table_reply_type       predicted_replies[$];
   table_request_type     next_req;
   table_reply_type       want;
   logic [KEY_BITS-1:0]   home_keys [HOME_KEYS];
   int unsigned           issued_count = 0;
   int unsigned           accepted_count = 0;
   int unsigned           gap_left = 0;
   int unsigned           error_count = 0;
   int unsigned           cycle_count = 0;
   bit                    burst_mode = 1'b0;
   bit                    drain_next = 1'b0;

   // Predicted table contents
   logic [KEY_BITS-1:0]   model_key   [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] model_value [TABLE_DEPTH];
   bit                    model_set   [TABLE_DEPTH];
   int unsigned           model_count = 0;
   logic [KEY_BITS-1:0]   fresh_key = KEY_MAX;

   keyed_reference_value_table DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_ref_key   (req_ref_key),
      .req_value_in  (req_value_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_key_out   (rsp_key_out)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // First entry holding this key, or -1
   function automatic int find_entry(input logic [KEY_BITS-1:0] key);
      int hit;
      hit = -1;
      for (int i = 0; i < int'(model_count); i++)
         if (hit < 0 && model_key[i] == key) hit = i;
      return hit;
   endfunction

   function automatic bit append_entry(input logic [KEY_BITS-1:0] key,
                                       input logic [VALUE_BITS-1:0] value, input bit mark);
      if (model_count >= TABLE_DEPTH) return 1'b0;
      model_key[model_count]   = key;
      model_value[model_count] = value;
      model_set[model_count]   = mark;
      model_count++;
      return 1'b1;
   endfunction

   // Overwrite an existing key, else append a key that is not above the limit if there is room
   function automatic logic [2:0] store_entry(input logic [KEY_BITS-1:0] key,
                                              input logic [VALUE_BITS-1:0] value);
      int idx;
      idx = find_entry(key);
      if (idx >= 0) begin
         model_value[idx] = value;
         model_set[idx]   = 1'b1;
         return STS_STORED;
      end
      if (key > KEY_LIMIT) return STS_ERROR;
      return append_entry(key, value, 1'b1) ? STS_STORED : STS_ERROR;
   endfunction

   // Apply one request to the predicted table and return its result
   function automatic table_reply_type apply_table_op(input logic [2:0] op,
                                                      input logic [KEY_BITS-1:0] key,
                                                      input logic [VALUE_BITS-1:0] value);
      table_reply_type r;
      int              idx;
      r.status = STS_ERROR;
      r.value  = '0;
      r.key    = key;
      case (op)
         OP_LOOKUP, OP_LOOKUP_STORE: begin
            if (key == '0) begin
               r.status = STS_NOOP;
               if (op == OP_LOOKUP_STORE) r.value = value;
            end else begin
               idx = find_entry(key);
               if (idx >= 0 && model_set[idx]) begin
                  r.status = STS_RETURNED;
                  r.value  = model_value[idx];
               end else if (op == OP_LOOKUP) begin
                  r.status = (idx >= 0) ? STS_NOT_SET : STS_NONEXISTENT;
               end else begin
                  r.status = store_entry(key, value);
                  if (r.status == STS_STORED) r.value = value;
               end
            end
         end
         OP_STORE: begin
            r.status = (key == '0) ? STS_NOOP : store_entry(key, value);
         end
         OP_CLEAR_ALL: begin
            for (int i = 0; i < TABLE_DEPTH; i++) model_set[i] = 1'b0;
            r.status = STS_STORED;
         end
         OP_ALLOCATE: begin
            if (append_entry(fresh_key, '0, 1'b0)) begin
               r.status  = STS_STORED;
               r.key     = fresh_key;
               fresh_key = fresh_key - 1'b1;
            end else begin
               r.key = '0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_word();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   // Mostly known keys so that lookups hit; some zero, allocated, boundary and wide keys
   function automatic logic [KEY_BITS-1:0] random_key();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) return '0;
      if (pick < 70) return home_keys[$urandom_range(0, HOME_KEYS - 1)];
      if (pick < 78) return KEY_MAX - KEY_BITS'($urandom_range(0, 3));
      if (pick < 86) return KEY_LIMIT + KEY_BITS'($urandom_range(0, 1));
      return KEY_BITS'($urandom);
   endfunction

   function automatic logic [2:0] random_op();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return OP_LOOKUP;
      if (pick < 55) return OP_STORE;
      if (pick < 85) return OP_LOOKUP_STORE;
      if (pick < 90) return OP_CLEAR_ALL;
      if (pick < 95) return OP_ALLOCATE;
      return 3'($urandom_range(OP_UNDEFINED_LO, OP_UNDEFINED_HI));
   endfunction

   task automatic push_request(input logic [2:0] op, input logic [KEY_BITS-1:0] key,
                               input logic [VALUE_BITS-1:0] value);
      table_request_type item;
      item.op    = op;
      item.key   = key;
      item.value = value;
      item.gap   = burst_mode ? 0 : $urandom_range(0, 6);
      item.drain = drain_next;
      drain_next = 1'b0;
      request_queue.push_back(item);
   endtask

   // Driver: hold a request until its transfer, then wait out its gap
   always @(negedge clock) begin
      if (!reset && issued_count == accepted_count) begin
         if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (request_queue.size() > 0 &&
                      !(request_queue[0].drain && predicted_replies.size() > 0)) begin
            next_req = request_queue.pop_front();
            start        <= 1'b1;
            req_op       <= next_req.op;
            req_ref_key  <= next_req.key;
            req_value_in <= next_req.value;
            gap_left     <= next_req.gap;
            issued_count <= issued_count + 1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check each result against the oldest prediction, then predict new transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (predicted_replies.size() == 0) begin
               $error("result with nothing predicted: status %0d", rsp_status);
               error_count++;
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_value_out !== want.value) begin
                  $error("value_out mismatch: expected %h, got %h", want.value, rsp_value_out);
                  error_count++;
               end
               if (rsp_key_out !== want.key) begin
                  $error("key_out mismatch: expected %h, got %h", want.key, rsp_key_out);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            predicted_replies.push_back(apply_table_op(req_op, req_ref_key, req_value_in));
            accepted_count++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      home_keys[0] = 31'd5;
      home_keys[1] = 31'd9;
      home_keys[2] = KEY_LIMIT;
      for (int i = 3; i < HOME_KEYS; i++)
         home_keys[i] = KEY_BITS'($urandom_range(1, 4095)) << $urandom_range(0, 18);

      // Directed: key zero, absent and unset keys, key limit, allocate, clear, bad ops
      push_request(OP_LOOKUP, '0, '1);
      push_request(OP_STORE, '0, '1);
      push_request(OP_LOOKUP_STORE, '0, 64'hA5A5_5A5A_F00D_BEEF);
      push_request(OP_LOOKUP, 31'd5, '0);
      push_request(OP_STORE, 31'd5, '1);
      push_request(OP_LOOKUP, 31'd5, '0);
      push_request(OP_STORE, KEY_LIMIT + 1'b1, '1);
      push_request(OP_STORE, KEY_LIMIT, '0);
      push_request(OP_STORE, KEY_MAX, random_word());
      push_request(OP_ALLOCATE, '0, '1);
      push_request(OP_LOOKUP, KEY_MAX, '0);
      push_request(OP_STORE, KEY_MAX, 64'h8000_0000_0000_0001);
      push_request(OP_LOOKUP, KEY_MAX, '1);
      push_request(OP_CLEAR_ALL, KEY_MAX, '1);
      push_request(OP_LOOKUP, 31'd5, '0);
      push_request(OP_LOOKUP_STORE, 31'd5, 64'h0123_4567_89AB_CDEF);
      push_request(OP_LOOKUP_STORE, 31'd5, 64'hFEDC_BA98_7654_3210);
      push_request(OP_LOOKUP_STORE, 31'd9, random_word());
      push_request(OP_LOOKUP_STORE, KEY_LIMIT + 1'b1, '1);
      for (int u = OP_UNDEFINED_LO; u <= OP_UNDEFINED_HI; u++)
         push_request(3'(u), KEY_BITS'($urandom), random_word());
      push_request(OP_ALLOCATE, KEY_BITS'($urandom), '0);

      // Random: bursts with no gaps now and then, occasional drain before a request
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
         drain_next = (n == 0) || ($urandom_range(0, 149) == 0);
         push_request(random_op(), random_key(), random_word());
      end

      // Release reset on a falling edge, clear of the driver's sample
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || issued_count != accepted_count ||
             predicted_replies.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (predicted_replies.size() != 0) begin
         $error("%0d predicted results never arrived", predicted_replies.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
